// ===== src/gsfr_pkg.sv =====
package gsfr_pkg;

  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int MS_W      = 20;
  localparam int WAIT_W    = 16;
  localparam int COUNT_W   = 4;

  // operation codes
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WARMUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

  localparam logic [7:0]         START_BYTE   = 8'hFF;
  localparam logic [MS_W-1:0]    MS_MAX       = {MS_W{1'b1}};
  localparam logic [COUNT_W-1:0] CHECKSUM_POS = 4'd8;

  // frame byte positions
  localparam logic [COUNT_W-1:0] POS_GAS     = 4'd1;
  localparam logic [COUNT_W-1:0] POS_DEC     = 4'd3;
  localparam logic [COUNT_W-1:0] POS_CONC_HI = 4'd4;
  localparam logic [COUNT_W-1:0] POS_CONC_LO = 4'd5;
  localparam logic [COUNT_W-1:0] POS_FS_HI   = 4'd6;
  localparam logic [COUNT_W-1:0] POS_FS_LO   = 4'd7;

  typedef struct packed {
    logic [15:0]         full_scale_tenths;
    logic [15:0]         concentration_tenths;
    logic [7:0]          decimal_places;
    logic [7:0]          gas_code;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// ===== src/gas_sensor_frame_receiver.sv =====
// Gas sensor frame receiver.
// Slave stream carries one word per event: tuser holds the operation
// (start request, received UART byte, one-millisecond tick), tdata holds
// the byte and the request timeout. The block hunts for the 0xFF start
// byte, gathers eight more bytes and checks the negated-sum checksum.
// A good frame ends the request with one result word; a bad one sends
// it back to hunting. A tick that reaches the timeout ends the request
// with a timeout status. Frames taken before warmup_ms ticks have passed
// since reset report a warm-up status with zero data.
// Master stream: tuser holds status, tdata the frame fields.
// An accepted word lands in the input register and is decoded from there
// into the result register, which drives the master side. Throughput:
// one word per cycle while results are taken; the decode is a single pass
// through the state update between the input and the result register.
// Reset clears both stages' valid flags and all request/timing state.
// When the master side stalls with a result held, the input register
// still drains if the word it holds produces no result; otherwise
// tready drops until the result is taken.
module gas_sensor_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  // configuration: warmup_ms
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] wait_limit_ms
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] gas_code, [15:8] decimal_places,
                                      // [31:16] concentration_tenths,
                                      // [47:32] full_scale_tenths
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic [gsfr_pkg::MS_W-1:0]   warmup_ms;

  // input register
  logic                        in_valid;
  logic [gsfr_pkg::OP_W-1:0]   in_op;
  logic [7:0]                  in_byte;
  logic [gsfr_pkg::WAIT_W-1:0] in_limit;

  // result register
  logic                        out_valid;
  gsfr_pkg::result_t           out_res;

  logic                        fire;
  logic                        res_valid;
  gsfr_pkg::result_t           res;

  // the decode stage only stalls when its result cannot be stored
  assign fire          = in_valid && (!out_valid || m_axis_tready || !res_valid);
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_ms <= '0;
    end else if (cfg_wr_en) begin
      warmup_ms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op    <= s_axis_tuser;
      in_byte  <= s_axis_tdata[7:0];
      in_limit <= s_axis_tdata[23:8];
    end
  end

  gsfr_core u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .operation     (in_op),
    .data_byte     (in_byte),
    .wait_limit_ms (in_limit),
    .warmup_ms     (warmup_ms),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {out_res.full_scale_tenths, out_res.concentration_tenths,
                          out_res.decimal_places, out_res.gas_code};

endmodule

// ===== src/gsfr_core.sv =====
module gsfr_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [gsfr_pkg::OP_W-1:0]     operation,
  input  logic [7:0]                    data_byte,
  input  logic [gsfr_pkg::WAIT_W-1:0]   wait_limit_ms,
  input  logic [gsfr_pkg::MS_W-1:0]     warmup_ms,
  output logic                          res_valid,
  output gsfr_pkg::result_t             res
);

  logic                               request_active, request_active_next;
  logic                               collecting, collecting_next;
  logic [gsfr_pkg::COUNT_W-1:0]       byte_count, byte_count_next;
  logic [7:0]                         running_sum, running_sum_next;
  logic [7:0]                         gas_hold, gas_hold_next;
  logic [7:0]                         decimals_hold, decimals_hold_next;
  logic [15:0]                        concentration_hold, concentration_hold_next;
  logic [15:0]                        full_scale_hold, full_scale_hold_next;
  logic [gsfr_pkg::WAIT_W-1:0]        timeout_limit, timeout_limit_next;
  logic [gsfr_pkg::WAIT_W-1:0]        elapsed_wait, elapsed_wait_next;
  logic [gsfr_pkg::MS_W-1:0]          ms_since_reset, ms_since_reset_next;
  logic [gsfr_pkg::WAIT_W:0]          elapsed_inc;
  logic [7:0]                         checksum;

  assign elapsed_inc = {1'b0, elapsed_wait} + {{gsfr_pkg::WAIT_W{1'b0}}, 1'b1};
  assign checksum    = 8'd0 - running_sum;

  always_comb begin
    request_active_next     = request_active;
    collecting_next         = collecting;
    byte_count_next         = byte_count;
    running_sum_next        = running_sum;
    gas_hold_next           = gas_hold;
    decimals_hold_next      = decimals_hold;
    concentration_hold_next = concentration_hold;
    full_scale_hold_next    = full_scale_hold;
    timeout_limit_next      = timeout_limit;
    elapsed_wait_next       = elapsed_wait;
    ms_since_reset_next     = ms_since_reset;
    res_valid               = 1'b0;
    res                     = '0;

    unique case (operation)
      gsfr_pkg::OP_START: begin
        request_active_next = 1'b1;
        collecting_next     = 1'b0;
        byte_count_next     = '0;
        running_sum_next    = '0;
        timeout_limit_next  = wait_limit_ms;
        elapsed_wait_next   = '0;
      end
      gsfr_pkg::OP_BYTE: begin
        if (request_active) begin
          if (!collecting) begin
            if (data_byte == gsfr_pkg::START_BYTE) begin
              collecting_next  = 1'b1;
              byte_count_next  = gsfr_pkg::COUNT_W'(1);
              running_sum_next = '0;
            end
          end else if (byte_count < gsfr_pkg::CHECKSUM_POS) begin
            running_sum_next = running_sum + data_byte;
            byte_count_next  = byte_count + gsfr_pkg::COUNT_W'(1);
            if (byte_count == gsfr_pkg::POS_GAS)     gas_hold_next = data_byte;
            if (byte_count == gsfr_pkg::POS_DEC)     decimals_hold_next = data_byte;
            if (byte_count == gsfr_pkg::POS_CONC_HI) concentration_hold_next[15:8] = data_byte;
            if (byte_count == gsfr_pkg::POS_CONC_LO) concentration_hold_next[7:0] = data_byte;
            if (byte_count == gsfr_pkg::POS_FS_HI)   full_scale_hold_next[15:8] = data_byte;
            if (byte_count == gsfr_pkg::POS_FS_LO)   full_scale_hold_next[7:0] = data_byte;
          end else begin
            // checksum byte: either way go back to hunting
            collecting_next  = 1'b0;
            byte_count_next  = '0;
            running_sum_next = '0;
            if (checksum == data_byte) begin
              request_active_next = 1'b0;
              res_valid           = 1'b1;
              if (ms_since_reset < warmup_ms) begin
                res.status = gsfr_pkg::ST_WARMUP;
              end else begin
                res.status               = gsfr_pkg::ST_OK;
                res.gas_code             = gas_hold;
                res.decimal_places       = decimals_hold;
                res.concentration_tenths = concentration_hold;
                res.full_scale_tenths    = full_scale_hold;
              end
            end
          end
        end
      end
      gsfr_pkg::OP_TICK: begin
        if (ms_since_reset != gsfr_pkg::MS_MAX) begin
          ms_since_reset_next = ms_since_reset + gsfr_pkg::MS_W'(1);
        end
        if (request_active) begin
          if (elapsed_inc >= {1'b0, timeout_limit}) begin
            elapsed_wait_next   = timeout_limit;
            request_active_next = 1'b0;
            collecting_next     = 1'b0;
            byte_count_next     = '0;
            running_sum_next    = '0;
            res_valid           = 1'b1;
            res.status          = gsfr_pkg::ST_TIMEOUT;
          end else begin
            elapsed_wait_next = elapsed_inc[gsfr_pkg::WAIT_W-1:0];
          end
        end
      end
      gsfr_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_active <= 1'b0;
      collecting     <= 1'b0;
      byte_count     <= '0;
      running_sum    <= '0;
      timeout_limit  <= '0;
      elapsed_wait   <= '0;
      ms_since_reset <= '0;
    end else if (fire) begin
      request_active <= request_active_next;
      collecting     <= collecting_next;
      byte_count     <= byte_count_next;
      running_sum    <= running_sum_next;
      timeout_limit  <= timeout_limit_next;
      elapsed_wait   <= elapsed_wait_next;
      ms_since_reset <= ms_since_reset_next;
    end
  end

  // frame fields are always written before a good checksum, no reset needed
  always_ff @(posedge clk) begin
    if (fire) begin
      gas_hold           <= gas_hold_next;
      decimals_hold      <= decimals_hold_next;
      concentration_hold <= concentration_hold_next;
      full_scale_hold    <= full_scale_hold_next;
    end
  end

endmodule
